// ----- hdl/frred_pkg.sv -----
`default_nettype none

package frred_pkg;

  localparam int unsigned Width  = 32;
  localparam int unsigned CntW   = $clog2(Width);
  localparam logic [Width-2:0] MaxMag = {(Width-1){1'b1}};
  localparam logic [CntW-1:0]  CntLast = CntW'(Width - 1);

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } frred_cmd_t;

  typedef struct packed {
    logic num_zero;
    logic gcd_done;
    logic cnt_last;
  } frred_sts_t;

endpackage

`default_nettype wire

// ----- hdl/frred_ctrl.sv -----
`default_nettype none

module frred_ctrl
  import frred_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire frred_sts_t sts_i,
  output frred_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StGcd,
    StDiv,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StGcd;
        end
      end
      StGcd: begin
        if (sts_i.num_zero) begin
          state_d = StDone;
        end else if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/frred_dp.sv -----
`default_nettype none

module frred_dp
  import frred_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire frred_cmd_t               cmd_i,
  output frred_sts_t                    sts_o,
  input  wire logic signed [Width-1:0]  numerator_in_i,
  input  wire logic signed [Width-1:0]  denominator_in_i,
  output logic signed [Width-1:0]       numerator_out_o,
  output logic [Width-2:0]              denominator_out_o
);

  logic [Width-1:0] nmag_q, dmag_q;
  logic             neg_q;
  logic [Width-1:0] a_q, b_q;
  logic [CntW-1:0]  k_q;
  logic [Width-1:0] div_q;
  logic [Width-1:0] xn_q, xd_q;
  logic [Width-1:0] rn_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic signed [Width-1:0] num_out_q;
  logic [Width-2:0] den_out_q;

  logic [Width-1:0] mag_n, mag_d;
  logic [Width:0]   rn_sh, rd_sh, rn_sub, rd_sub;
  logic             qn_bit, qd_bit;
  logic [Width-2:0] sat_n, sat_d;
  logic [Width-1:0] num_pos;

  assign mag_n = numerator_in_i[Width-1] ? (~numerator_in_i + 1'b1) : numerator_in_i;
  assign mag_d = denominator_in_i[Width-1] ? (~denominator_in_i + 1'b1) : denominator_in_i;

  assign rn_sh  = {rn_q, xn_q[Width-1]};
  assign rd_sh  = {rd_q, xd_q[Width-1]};
  assign rn_sub = rn_sh - {1'b0, div_q};
  assign rd_sub = rd_sh - {1'b0, div_q};
  assign qn_bit = (rn_sh >= {1'b0, div_q});
  assign qd_bit = (rd_sh >= {1'b0, div_q});

  assign sat_n   = xn_q[Width-1] ? MaxMag : xn_q[Width-2:0];
  assign sat_d   = xd_q[Width-1] ? MaxMag : xd_q[Width-2:0];
  assign num_pos = {1'b0, sat_n};

  assign sts_o.num_zero = (nmag_q == '0);
  assign sts_o.gcd_done = (b_q == '0);
  assign sts_o.cnt_last = (cnt_q == CntLast);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nmag_q <= mag_n;
      dmag_q <= mag_d;
      neg_q  <= numerator_in_i[Width-1] ^ denominator_in_i[Width-1];
      a_q    <= mag_n;
      b_q    <= mag_d;
      k_q    <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end

    if (cmd_i.div_init) begin
      div_q <= a_q << k_q;
      xn_q  <= nmag_q;
      xd_q  <= dmag_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q  <= qn_bit ? rn_sub[Width-1:0] : rn_sh[Width-1:0];
      rd_q  <= qd_bit ? rd_sub[Width-1:0] : rd_sh[Width-1:0];
      xn_q  <= {xn_q[Width-2:0], qn_bit};
      xd_q  <= {xd_q[Width-2:0], qd_bit};
      cnt_q <= cnt_q + 1'b1;
    end

    if (cmd_i.out_load) begin
      if (nmag_q == '0) begin
        num_out_q <= '0;
        den_out_q <= (Width-1)'(1);
      end else begin
        num_out_q <= neg_q ? (~num_pos + 1'b1) : num_pos;
        den_out_q <= sat_d;
      end
    end
  end

  assign numerator_out_o   = num_out_q;
  assign denominator_out_o = den_out_q;

endmodule

`default_nettype wire

// ----- hdl/fraction_reducer_top.sv -----
`default_nettype none

// Reduces a signed fraction to lowest terms with a non-negative denominator.
// One transaction is worked on at a time: a binary gcd that takes one
// subtract or shift per cycle, then a bit-serial restoring divide of both
// magnitudes by the gcd in parallel, then a load of the output register
// once that register is free. A zero numerator skips the gcd and the
// divide and returns 0/1. A zero denominator gives +1/0 or -1/0. A new
// transaction is accepted while the previous result still waits in the
// output register.
module fraction_reducer_top
  import frred_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [Width-1:0]  numerator_in_i,
  input  wire logic signed [Width-1:0]  denominator_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [Width-1:0]       numerator_out_o,
  output logic [Width-2:0]              denominator_out_o
);

  frred_cmd_t cmd;
  frred_sts_t sts;

  frred_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  frred_dp u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .numerator_in_i    (numerator_in_i),
    .denominator_in_i  (denominator_in_i),
    .numerator_out_o   (numerator_out_o),
    .denominator_out_o (denominator_out_o)
  );

endmodule

`default_nettype wire
